// ===== rtl/tcco_pkg.sv =====
`timescale 1ns / 1ps
package tcco_pkg;

    // Request modes
    typedef enum logic [1:0] {
        MODE_NODE = 2'd0,
        MODE_CELL = 2'd1,
        MODE_FACE = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TAG       = 3'd1,
        ST_DUP       = 3'd2,
        ST_RANGE     = 3'd3,
        ST_DEGEN     = 3'd4
    } t_status;

    // Configuration register indexes
    localparam logic [0:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [0:0] CFG_DEG_LIMIT  = 1'b1;

    localparam int ID_W     = 16;
    localparam int CNT_W    = 13;
    localparam int LIMIT_W  = 51;
    localparam int VOL_W    = 52;
    localparam int DET_W    = 64;
    localparam int EFF_W    = 17;

    typedef struct packed {
        t_mode              mode;
        logic [11:0]        node_index;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic signed [15:0] id_first;
        logic signed [15:0] id_second;
        logic signed [15:0] id_third;
        logic signed [15:0] id_fourth;
        logic signed [15:0] tag;
    } t_in_req;

    typedef struct packed {
        t_status            status;
        logic signed [51:0] six_volume;
        logic               swapped;
        logic signed [15:0] out_first;
        logic signed [15:0] out_second;
    } t_out_rsp;

    // Request data that travels alongside the determinant pipeline
    typedef struct packed {
        t_mode              mode;
        t_status            status;
        logic signed [15:0] first;
        logic signed [15:0] second;
    } t_side;

endpackage

// ===== rtl/tcco_node_mem.sv =====
`timescale 1ns / 1ps
module tcco_node_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int W     = 48
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcco_id_check.sv =====
`timescale 1ns / 1ps
module tcco_id_check (
    input  tcco_pkg::t_in_req              i_req,
    input  logic [tcco_pkg::EFF_W-1:0]     i_count,
    output tcco_pkg::t_status              o_status
);

    logic signed [15:0] ids [4];
    logic               dup;
    logic               oor;
    logic               is_cell;

    always_comb begin
        ids[0]  = i_req.id_first;
        ids[1]  = i_req.id_second;
        ids[2]  = i_req.id_third;
        ids[3]  = i_req.id_fourth;
        is_cell = (i_req.mode == tcco_pkg::MODE_CELL);
        dup     = 1'b0;
        oor     = 1'b0;
        // pairwise duplicates; fourth id only for cells
        for (int i = 0; i < 4; i++) begin
            for (int j = i + 1; j < 4; j++) begin
                if ((j < 3 || is_cell) && ids[i] == ids[j]) begin
                    dup = 1'b1;
                end
            end
        end
        for (int i = 0; i < 4; i++) begin
            if ((i < 3 || is_cell) &&
                (ids[i][15] || tcco_pkg::EFF_W'(ids[i][14:0]) >= i_count)) begin
                oor = 1'b1;
            end
        end
        if (i_req.tag[15] || i_req.tag == 16'sd0) begin
            o_status = tcco_pkg::ST_TAG;
        end else if (dup) begin
            o_status = tcco_pkg::ST_DUP;
        end else if (oor) begin
            o_status = tcco_pkg::ST_RANGE;
        end else begin
            o_status = tcco_pkg::ST_OK;
        end
    end

endmodule

// ===== rtl/tcco_det.sv =====
`timescale 1ns / 1ps
module tcco_det #(
    parameter int CB = 16
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [3:0][3*CB-1:0]             i_nodes,
    output logic signed [tcco_pkg::DET_W-1:0] o_det
);

    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;
    localparam int MW = PW + 1;
    localparam int TW = DW + MW;

    logic signed [CB-1:0] c [4][3];
    logic signed [DW-1:0] r_e [3][3];
    logic signed [DW-1:0] r_row_c [3];
    logic signed [PW-1:0] r_p [6];
    logic signed [DW-1:0] r_row_d [3];
    logic signed [MW-1:0] r_m [3];
    logic signed [TW-1:0] r_t [3];
    logic signed [tcco_pkg::DET_W-1:0] r_det;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int a = 0; a < 3; a++) begin
                c[k][a] = signed'(i_nodes[k][a*CB +: CB]);
            end
        end
    end

    // Edge vectors from the first node
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                for (int a = 0; a < 3; a++) begin
                    r_e[k][a] <= DW'(c[k+1][a]) - DW'(c[0][a]);
                end
            end
        end
    end

    // 2x2 cofactor products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= PW'(r_e[1][1]) * PW'(r_e[2][2]);
            r_p[1] <= PW'(r_e[1][2]) * PW'(r_e[2][1]);
            r_p[2] <= PW'(r_e[1][0]) * PW'(r_e[2][2]);
            r_p[3] <= PW'(r_e[1][2]) * PW'(r_e[2][0]);
            r_p[4] <= PW'(r_e[1][0]) * PW'(r_e[2][1]);
            r_p[5] <= PW'(r_e[1][1]) * PW'(r_e[2][0]);
            for (int a = 0; a < 3; a++) begin
                r_row_c[a] <= r_e[0][a];
            end
        end
    end

    // Minors
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= MW'(r_p[0]) - MW'(r_p[1]);
            r_m[1] <= MW'(r_p[2]) - MW'(r_p[3]);
            r_m[2] <= MW'(r_p[4]) - MW'(r_p[5]);
            for (int a = 0; a < 3; a++) begin
                r_row_d[a] <= r_row_c[a];
            end
        end
    end

    // First-row terms
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_t[a] <= TW'(r_row_d[a]) * TW'(r_m[a]);
            end
        end
    end

    // Expansion sum, wraps at 64 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det <= tcco_pkg::DET_W'(r_t[0]) - tcco_pkg::DET_W'(r_t[1])
                   + tcco_pkg::DET_W'(r_t[2]);
        end
    end

    assign o_det = r_det;

endmodule

// ===== rtl/tetra_cell_check_orient_unit.sv =====
`timescale 1ns / 1ps
// Tetrahedral cell check and orientation unit. Takes one request per cycle while
// downstream keeps up; a request passes the node store read register, the
// determinant stages and the output register before o_valid rises. Node writes
// (mode 0), cell checks (mode 1) and face checks (mode 2) may be freely
// interleaved; a check sees every node write accepted before it. The rate is set
// by the node store, held as four identical copies so the four corner nodes of a
// cell are read together, feeding a five-stage determinant pipeline. A two-entry
// output buffer lets one result wait while the pipeline keeps moving; o_stall
// rises only once a second result is parked. Configuration must be written only
// while no request is in flight; the user, not the block, enforces it. Node
// slots read by a check must have been written first; the store has no reset.
module tetra_cell_check_orient_unit #(
    parameter int MAX_NODES  = 4096,
    parameter int COORD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  tcco_pkg::t_in_req                 i_req,
    output logic                              o_valid,
    input  logic                              i_stall,
    output tcco_pkg::t_out_rsp                o_rsp,
    input  logic                              i_cfg_we,
    input  logic [0:0]                        i_cfg_idx,
    input  logic [tcco_pkg::LIMIT_W-1:0]      i_cfg_data
);

    localparam int AW   = $clog2(MAX_NODES);
    localparam int NW   = 3 * COORD_BITS;
    localparam int NSTG = 6;

    logic [tcco_pkg::CNT_W-1:0]   r_node_count;
    logic [tcco_pkg::LIMIT_W-1:0] r_deg_limit;
    logic [tcco_pkg::EFF_W-1:0]   eff_count;
    logic                         en;
    logic                         acc;
    logic                         mem_we;
    logic [31:0]                  widx;
    logic [NW-1:0]                wdata;
    logic [3:0][AW-1:0]           raddr;
    logic [3:0][NW-1:0]           nodes;
    logic signed [tcco_pkg::DET_W-1:0] det;
    logic [tcco_pkg::DET_W-1:0]   mag;
    tcco_pkg::t_status            chk_status;
    tcco_pkg::t_side              n_side;
    logic                         r_sv   [NSTG];
    tcco_pkg::t_side              r_side [NSTG];
    tcco_pkg::t_out_rsp           n_res;
    logic                         r_ov;
    tcco_pkg::t_out_rsp           r_out;
    logic                         r_skv;
    tcco_pkg::t_out_rsp           r_skid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
            r_deg_limit  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tcco_pkg::CFG_NODE_COUNT) begin
                r_node_count <= i_cfg_data[tcco_pkg::CNT_W-1:0];
            end else if (i_cfg_idx == tcco_pkg::CFG_DEG_LIMIT) begin
                r_deg_limit <= i_cfg_data;
            end
        end
    end

    assign eff_count = (tcco_pkg::EFF_W'(r_node_count) < tcco_pkg::EFF_W'(MAX_NODES))
                     ? tcco_pkg::EFF_W'(r_node_count) : tcco_pkg::EFF_W'(MAX_NODES);

    // Pipeline moves whenever the skid slot is free
    assign en      = !r_skv;
    assign o_stall = !en;
    assign acc     = i_valid && en;

    // Node store write; coordinate bits beyond the field read as zero
    assign widx   = 32'(i_req.node_index);
    assign mem_we = acc && (i_req.mode == tcco_pkg::MODE_NODE) && (widx < 32'(MAX_NODES));
    assign wdata  = {COORD_BITS'($unsigned(i_req.coord_z)),
                     COORD_BITS'($unsigned(i_req.coord_y)),
                     COORD_BITS'($unsigned(i_req.coord_x))};
    assign raddr[0] = i_req.id_first[AW-1:0];
    assign raddr[1] = i_req.id_second[AW-1:0];
    assign raddr[2] = i_req.id_third[AW-1:0];
    assign raddr[3] = i_req.id_fourth[AW-1:0];

    for (genvar g = 0; g < 4; g++) begin : g_mem
        tcco_node_mem #(
            .DEPTH (MAX_NODES),
            .AW    (AW),
            .W     (NW)
        ) u_mem (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_we    (mem_we),
            .i_waddr (widx[AW-1:0]),
            .i_wdata (wdata),
            .i_raddr (raddr[g]),
            .o_rdata (nodes[g])
        );
    end

    tcco_id_check u_check (
        .i_req    (i_req),
        .i_count  (eff_count),
        .o_status (chk_status)
    );

    tcco_det #(
        .CB (COORD_BITS)
    ) u_det (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_nodes (nodes),
        .o_det   (det)
    );

    // Side data follows the determinant pipeline
    always_comb begin
        n_side.mode   = i_req.mode;
        n_side.status = chk_status;
        n_side.first  = i_req.id_first;
        n_side.second = i_req.id_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) begin
                r_sv[s] <= 1'b0;
            end
        end else if (en) begin
            r_sv[0] <= acc;
            for (int s = 1; s < NSTG; s++) begin
                r_sv[s] <= r_sv[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int s = 1; s < NSTG; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // Result assembly: orientation and degeneracy
    assign mag = det[tcco_pkg::DET_W-1] ? tcco_pkg::DET_W'(-det) : tcco_pkg::DET_W'(det);

    always_comb begin
        n_res = '0;
        case (r_side[NSTG-1].mode)
            tcco_pkg::MODE_CELL: begin
                n_res.status     = r_side[NSTG-1].status;
                n_res.out_first  = r_side[NSTG-1].first;
                n_res.out_second = r_side[NSTG-1].second;
                if (r_side[NSTG-1].status == tcco_pkg::ST_OK) begin
                    n_res.six_volume = det[tcco_pkg::VOL_W-1:0];
                    if (det[tcco_pkg::DET_W-1]) begin
                        n_res.swapped    = 1'b1;
                        n_res.out_first  = r_side[NSTG-1].second;
                        n_res.out_second = r_side[NSTG-1].first;
                    end
                    if (mag <= tcco_pkg::DET_W'(r_deg_limit)) begin
                        n_res.status = tcco_pkg::ST_DEGEN;
                    end
                end
            end
            tcco_pkg::MODE_FACE: begin
                n_res.status     = r_side[NSTG-1].status;
                n_res.out_first  = r_side[NSTG-1].first;
                n_res.out_second = r_side[NSTG-1].second;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // Output register with skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (r_skv) begin
            if (!r_ov || !i_stall) begin
                r_out <= r_skid;
                r_ov  <= 1'b1;
                r_skv <= 1'b0;
            end
        end else if (r_sv[NSTG-1]) begin
            if (!r_ov || !i_stall) begin
                r_out <= n_res;
                r_ov  <= 1'b1;
            end else begin
                r_skid <= n_res;
                r_skv  <= 1'b1;
            end
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid = r_ov;
    assign o_rsp   = r_out;

endmodule

// ===== rtl/tcco_checker.sv =====
`timescale 1ns / 1ps
module tcco_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input tcco_pkg::t_out_rsp o_rsp
);

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("stalled result changed");

    // Failed checks carry no volume and no swap
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status == tcco_pkg::ST_TAG || o_rsp.status == tcco_pkg::ST_DUP ||
                    o_rsp.status == tcco_pkg::ST_RANGE)
        |-> o_rsp.six_volume == '0 && !o_rsp.swapped)
        else $error("failed check with volume or swap");

    // A swap only follows a passed cell
    a_swap_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.swapped
        |-> o_rsp.status == tcco_pkg::ST_OK || o_rsp.status == tcco_pkg::ST_DEGEN)
        else $error("swap on failed request");

endmodule

bind tetra_cell_check_orient_unit tcco_checker u_tcco_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);

// ===== bench/tetra_cell_check_orient_unit_tb.sv =====
`timescale 1ns / 1ps
module tetra_cell_check_orient_unit_tb;

    localparam int NODES      = 4096;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 12;
    localparam logic [tcco_pkg::LIMIT_W-1:0] LIMIT_TOP = {tcco_pkg::LIMIT_W{1'b1}};

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    tcco_pkg::t_in_req            i_req;
    logic                         o_valid;
    logic                         i_stall;
    tcco_pkg::t_out_rsp           o_rsp;
    logic                         i_cfg_we;
    logic [0:0]                   i_cfg_idx;
    logic [tcco_pkg::LIMIT_W-1:0] i_cfg_data;

    tetra_cell_check_orient_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: node coordinates, which slots were written, registers
    logic [47:0]                  coord_mem [NODES];
    bit                           slot_written [NODES];
    int                           written_slots [$];
    logic [tcco_pkg::CNT_W-1:0]   node_count_q;
    logic [tcco_pkg::LIMIT_W-1:0] limit_q;

    tcco_pkg::t_out_rsp pending_rsp [$];
    int                 fail_count;
    int                 cycle_count;
    int                 rsp_count;
    int                 status_hits [5];
    int                 swap_hits;

    // Idling controls shared with the response side
    bit                 quiet_tx;
    bit                 quiet_rx;
    int                 hold_token;
    int                 hold_seen;
    int                 hold_left;
    int                 stall_run;

    typedef struct {
        tcco_pkg::t_in_req  req;
        bit                 typed;
        tcco_pkg::t_out_rsp rsp;
    } t_row;

    t_row stim_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at response %0d: %s got %0h expected %0h",
                 rsp_count, what, got, want);
        fail_count++;
    endtask

    function automatic longint coord_at(int slot, int axis);
        logic [47:0] w;
        w = coord_mem[slot];
        return longint'($signed(w[16*axis +: 16]));
    endfunction

    function automatic longint eff_count();
        return (node_count_q > NODES) ? NODES : longint'(node_count_q);
    endfunction

    // Tag first, then duplicates, then range
    function automatic tcco_pkg::t_status id_status(longint ids[4], int n, longint tag);
        if (tag <= 0) return tcco_pkg::ST_TAG;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (ids[i] == ids[j]) return tcco_pkg::ST_DUP;
        for (int i = 0; i < n; i++)
            if (ids[i] < 0 || ids[i] >= eff_count()) return tcco_pkg::ST_RANGE;
        return tcco_pkg::ST_OK;
    endfunction

    function automatic void unpack_ids(tcco_pkg::t_in_req r, output longint ids[4]);
        ids[0] = longint'(r.id_first);
        ids[1] = longint'(r.id_second);
        ids[2] = longint'(r.id_third);
        ids[3] = longint'(r.id_fourth);
    endfunction

    // True when a cell would pass its id checks and touch a blank slot
    function automatic bit reads_blank(tcco_pkg::t_in_req r);
        longint ids[4];
        unpack_ids(r, ids);
        if (r.mode != tcco_pkg::MODE_CELL) return 0;
        if (id_status(ids, 4, longint'(r.tag)) != tcco_pkg::ST_OK) return 0;
        for (int k = 0; k < 4; k++)
            if (!slot_written[ids[k]]) return 1;
        return 0;
    endfunction

    function automatic tcco_pkg::t_out_rsp orient_cell(tcco_pkg::t_in_req r);
        tcco_pkg::t_out_rsp rsp;
        longint             ids[4];
        longint             e[3][3];
        longint             det;
        longint             mag;
        rsp = '0;
        if (r.mode == tcco_pkg::MODE_NODE) begin
            coord_mem[r.node_index] = {r.coord_z, r.coord_y, r.coord_x};
            if (!slot_written[r.node_index]) begin
                slot_written[r.node_index] = 1;
                written_slots.insert(written_slots.size(), int'(r.node_index));
            end
            return rsp;
        end
        if (r.mode == tcco_pkg::MODE_NONE) return rsp;
        unpack_ids(r, ids);
        rsp.out_first  = r.id_first;
        rsp.out_second = r.id_second;
        if (r.mode == tcco_pkg::MODE_FACE) begin
            rsp.status = id_status(ids, 3, longint'(r.tag));
            return rsp;
        end
        rsp.status = id_status(ids, 4, longint'(r.tag));
        if (rsp.status != tcco_pkg::ST_OK) return rsp;
        for (int k = 0; k < 3; k++)
            for (int ax = 0; ax < 3; ax++)
                e[k][ax] = coord_at(ids[k+1], ax) - coord_at(ids[0], ax);
        det = e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
            - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
            + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
        rsp.six_volume = det[tcco_pkg::VOL_W-1:0];
        if (det < 0) begin
            rsp.swapped    = 1'b1;
            rsp.out_first  = r.id_second;
            rsp.out_second = r.id_first;
        end
        mag = (det < 0) ? -det : det;
        if (mag <= longint'({13'd0, limit_q})) rsp.status = tcco_pkg::ST_DEGEN;
        return rsp;
    endfunction

    function automatic tcco_pkg::t_in_req mk_req(tcco_pkg::t_mode m, int slot,
                                                 int x, int y, int z,
                                                 int a, int b, int c, int d, int tag);
        tcco_pkg::t_in_req r;
        r.mode       = m;
        r.node_index = slot[11:0];
        r.coord_x    = x[15:0];
        r.coord_y    = y[15:0];
        r.coord_z    = z[15:0];
        r.id_first   = a[15:0];
        r.id_second  = b[15:0];
        r.id_third   = c[15:0];
        r.id_fourth  = d[15:0];
        r.tag        = tag[15:0];
        return r;
    endfunction

    function automatic void add_row(tcco_pkg::t_in_req r, bit typed, tcco_pkg::t_status st);
        t_row row;
        row.req   = r;
        row.typed = typed;
        row.rsp   = '0;
        if (typed && r.mode inside {tcco_pkg::MODE_CELL, tcco_pkg::MODE_FACE}) begin
            row.rsp.status     = st;
            row.rsp.out_first  = r.id_first;
            row.rsp.out_second = r.id_second;
        end
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    function automatic int pick_gap(bit quiet);
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Picks a written slot below the active count, falling back to any slot
    function automatic int pick_slot();
        int s;
        for (int tries = 0; tries < 64; tries++) begin
            s = written_slots[$urandom_range(written_slots.size() - 1)];
            if (s < eff_count()) return s;
        end
        return $urandom_range(NODES - 1);
    endfunction

    function automatic tcco_pkg::t_in_req random_req(int node_pct);
        tcco_pkg::t_in_req r;
        int                roll;
        int                ids[4];
        r = tcco_pkg::t_in_req'({$urandom, $urandom, $urandom, $urandom, $urandom});
        roll = $urandom_range(99);
        if (roll < node_pct) begin
            r.mode = tcco_pkg::MODE_NODE;
            return r;
        end
        roll = $urandom_range(99);
        if (roll < 4) begin
            r.mode = tcco_pkg::MODE_NONE;
            return r;
        end
        r.mode = (roll < 70) ? tcco_pkg::MODE_CELL : tcco_pkg::MODE_FACE;
        roll = $urandom_range(99);
        if (roll < 70 && eff_count() >= 4) begin
            // well-formed: distinct written slots, positive tag
            for (int k = 0; k < 4; k++) begin
                ids[k] = pick_slot();
                for (int j = 0; j < k; j++)
                    if (ids[j] == ids[k]) begin
                        ids[k] = pick_slot();
                        j = -1;
                    end
            end
            r.id_first  = ids[0][15:0];
            r.id_second = ids[1][15:0];
            r.id_third  = ids[2][15:0];
            r.id_fourth = ids[3][15:0];
            r.tag       = 16'($urandom_range(32767, 1));
        end else if (roll < 80) begin
            r.id_third = r.id_first;
            r.tag      = 16'($urandom_range(32767, 1));
        end else if (roll < 90) begin
            r.id_second = 16'(eff_count() + $urandom_range(3));
            r.tag       = 16'($urandom_range(32767, 1));
        end
        if (reads_blank(r)) r.tag = '0;
        return r;
    endfunction

    task automatic cfg_write(input logic [0:0] idx,
                             input logic [tcco_pkg::LIMIT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == tcco_pkg::CFG_NODE_COUNT) node_count_q = data[tcco_pkg::CNT_W-1:0];
        else limit_q = data;
    endtask

    task automatic wait_idle();
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Offers one request, then records its expected response on acceptance
    task automatic send_req(input tcco_pkg::t_in_req r, input bit typed,
                            input tcco_pkg::t_out_rsp want);
        int                 gap;
        tcco_pkg::t_out_rsp calc;
        gap = pick_gap(quiet_tx);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        calc = orient_cell(r);
        pending_rsp.insert(pending_rsp.size(), typed ? want : calc);
    endtask

    task automatic send_random(input int count, input int node_pct);
        tcco_pkg::t_in_req r;
        for (int n = 0; n < count; n++) begin
            r = random_req(node_pct);
            send_req(r, 0, '0);
        end
        i_valid <= 1'b0;
    endtask

    // Response check and downstream stall
    always @(posedge i_clk) begin
        tcco_pkg::t_out_rsp want;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_rsp.size() == 0) begin
                    report_mismatch("unexpected response", 64'd1, 64'd0);
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_rsp.status != want.status)
                        report_mismatch("status", o_rsp.status, want.status);
                    if (o_rsp.six_volume != want.six_volume)
                        report_mismatch("six_volume", o_rsp.six_volume, want.six_volume);
                    if (o_rsp.swapped != want.swapped)
                        report_mismatch("swapped", o_rsp.swapped, want.swapped);
                    if (o_rsp.out_first != want.out_first)
                        report_mismatch("out_first", o_rsp.out_first, want.out_first);
                    if (o_rsp.out_second != want.out_second)
                        report_mismatch("out_second", o_rsp.out_second, want.out_second);
                    if (want.status <= tcco_pkg::ST_DEGEN) status_hits[want.status]++;
                    swap_hits += want.swapped;
                end
                rsp_count++;
            end
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = 250;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (quiet_rx) begin
                i_stall <= 1'b0;
            end else if (stall_run > 0) begin
                stall_run--;
                i_stall <= 1'b1;
            end else begin
                stall_run = pick_gap(0);
                i_stall <= (stall_run > 0);
                if (stall_run > 0) stall_run--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        tcco_pkg::t_in_req r;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = tcco_pkg::CFG_NODE_COUNT;
        i_cfg_data  = '0;
        fail_count  = 0;
        cycle_count = 0;
        rsp_count   = 0;
        swap_hits   = 0;
        quiet_tx    = 0;
        quiet_rx    = 0;
        hold_token  = 0;
        hold_seen   = 0;
        hold_left   = 0;
        stall_run   = 0;
        node_count_q = '0;
        limit_q      = '0;
        foreach (slot_written[k]) slot_written[k] = 0;
        foreach (status_hits[k]) status_hits[k] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unit tetrahedron, flips, each error, extremes
        cfg_write(tcco_pkg::CFG_NODE_COUNT, 8);
        cfg_write(tcco_pkg::CFG_DEG_LIMIT, 0);
        add_row(mk_req(tcco_pkg::MODE_NODE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_NODE, 1, 4096, 0, 0, 0, 0, 0, 0, 0), 1, tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_NODE, 2, 0, 4096, 0, 0, 0, 0, 0, 0), 1, tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_NODE, 3, 0, 0, 4096, 0, 0, 0, 0, 0), 1, tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_NODE, 4, 32767, -32768, 32767, 0, 0, 0, 0, 0), 1,
                tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_NODE, 5, 4096, 4096, 0, 0, 0, 0, 0, 0), 1,
                tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_NODE, 6, -32768, 32767, -32768, 0, 0, 0, 0, 0), 1,
                tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_NODE, 7, -1, -1, -1, 0, 0, 0, 0, 0), 1, tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_NODE, 4095, 1, 2, 3, 0, 0, 0, 0, 0), 1, tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_CELL, 0, 0, 0, 0, 0, 1, 2, 3, 1), 0, tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_CELL, 0, 0, 0, 0, 1, 0, 2, 3, 32767), 0, tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_CELL, 0, 0, 0, 0, 0, 1, 2, 5, 9), 0, tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_CELL, 0, 0, 0, 0, 4, 6, 7, 3, 2), 0, tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_CELL, 0, 0, 0, 0, 6, 4, 1, 2, 2), 0, tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_CELL, 0, 0, 0, 0, 0, 1, 2, 3, 0), 1, tcco_pkg::ST_TAG);
        add_row(mk_req(tcco_pkg::MODE_CELL, 0, 0, 0, 0, 0, 1, 2, 3, -32768), 1,
                tcco_pkg::ST_TAG);
        add_row(mk_req(tcco_pkg::MODE_CELL, 0, 0, 0, 0, 0, 1, 2, 0, 5), 1, tcco_pkg::ST_DUP);
        add_row(mk_req(tcco_pkg::MODE_CELL, 0, 0, 0, 0, 0, 1, 2, 8, 5), 1, tcco_pkg::ST_RANGE);
        add_row(mk_req(tcco_pkg::MODE_CELL, 0, 0, 0, 0, -1, 1, 2, 3, 5), 1, tcco_pkg::ST_RANGE);
        add_row(mk_req(tcco_pkg::MODE_CELL, 0, 0, 0, 0, 32767, -32768, 2, 3, 5), 1,
                tcco_pkg::ST_RANGE);
        add_row(mk_req(tcco_pkg::MODE_FACE, 0, 0, 0, 0, 0, 1, 2, 2, 3), 1, tcco_pkg::ST_OK);
        add_row(mk_req(tcco_pkg::MODE_FACE, 0, 0, 0, 0, 0, 1, 1, 5, 3), 1, tcco_pkg::ST_DUP);
        add_row(mk_req(tcco_pkg::MODE_FACE, 0, 0, 0, 0, 0, 1, 2, 3, -1), 1, tcco_pkg::ST_TAG);
        add_row(mk_req(tcco_pkg::MODE_NONE, 0, 1, 2, 3, 4, 5, 6, 7, 8), 1, tcco_pkg::ST_OK);
        foreach (stim_rows[k])
            send_req(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].rsp);
        i_valid <= 1'b0;
        wait_idle();

        // Small mesh, tight limit: load slots 0..63 then mixed traffic
        cfg_write(tcco_pkg::CFG_NODE_COUNT, 64);
        for (int s = 0; s < 64; s++) begin
            r = tcco_pkg::t_in_req'({$urandom, $urandom, $urandom, $urandom, $urandom});
            r.mode = tcco_pkg::MODE_NODE;
            r.node_index = 12'(s);
            send_req(r, 0, '0);
        end
        send_random(110, 15);
        wait_idle();

        // Four nodes, widest limit: every passing cell is degenerate
        cfg_write(tcco_pkg::CFG_NODE_COUNT, 4);
        cfg_write(tcco_pkg::CFG_DEG_LIMIT, LIMIT_TOP);
        send_random(40, 10);
        wait_idle();

        // Count above the store size, mid limit, part of it with no idling
        cfg_write(tcco_pkg::CFG_NODE_COUNT, 8191);
        cfg_write(tcco_pkg::CFG_DEG_LIMIT,
                  tcco_pkg::LIMIT_W'({$urandom_range(255), 32'd0})
                  | tcco_pkg::LIMIT_W'($urandom));
        send_random(50, 25);
        quiet_tx = 1;
        quiet_rx = 1;
        send_random(50, 25);
        quiet_rx = 0;
        wait_idle();

        // Long downstream hold while requests keep coming
        cfg_write(tcco_pkg::CFG_NODE_COUNT, 4096);
        cfg_write(tcco_pkg::CFG_DEG_LIMIT, 0);
        hold_token++;
        send_random(40, 20);
        quiet_tx = 0;
        wait_idle();

        // No nodes in use: every check fails on tag, duplicate or range
        cfg_write(tcco_pkg::CFG_NODE_COUNT, 0);
        send_random(30, 10);

        wait_idle();
        $display("checked %0d responses: ok %0d, tag %0d, dup %0d, range %0d, degenerate %0d",
                 rsp_count, status_hits[tcco_pkg::ST_OK], status_hits[tcco_pkg::ST_TAG],
                 status_hits[tcco_pkg::ST_DUP], status_hits[tcco_pkg::ST_RANGE],
                 status_hits[tcco_pkg::ST_DEGEN]);
        $display("orientation flips %0d, node counts 0 to 8191, limits 0 to full scale",
                 swap_hits);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== tetra_cell_check_orient_unit.f =====
rtl/tcco_pkg.sv
rtl/tcco_node_mem.sv
rtl/tcco_id_check.sv
rtl/tcco_det.sv
rtl/tetra_cell_check_orient_unit.sv
rtl/tcco_checker.sv
bench/tetra_cell_check_orient_unit_tb.sv
